// ===== rtl/sagu_pkg.sv =====
// shared types, field widths and elaboration-time tables for the seirs grid update block
// no dependencies; imported by the top level
`default_nettype none

package sagu_pkg;

  localparam int GRID_SIZE_DEF    = 256;
  localparam int PROB_ENTRIES_DEF = 64;

  localparam int OP_W       = 2;
  localparam int DAYS_W     = 12;
  localparam int DRAW_W     = 32;
  localparam int CELL_W     = 16;
  localparam int SEEN_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 72;

  localparam int COORD_IN_N       = 256;
  localparam int COORD_MAX_W      = 10;
  localparam int PROB_MAX_ENTRIES = 256;

  localparam logic [DAYS_W-1:0] DAYS_MAX     = '1;
  localparam logic [CELL_W-1:0] CELL_MAX     = '1;
  localparam logic [63:0]       EXP_HALF_Q32 = 64'd2605029347;
  localparam logic [63:0]       ONE_Q32      = 64'h0000_0001_0000_0000;
  localparam logic [63:0]       HALF_LSB_Q32 = 64'h0000_0000_8000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR,
    OP_ADD,
    OP_UPDATE
  } op_t;

  typedef enum logic [1:0] {
    AG_SUS,
    AG_EXP,
    AG_INF,
    AG_REC
  } agent_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COMPARE_MODE,
    CFG_REDRAW_ENABLE,
    CFG_LIVE_GRID
  } cfg_idx_t;

  typedef logic [PROB_MAX_ENTRIES-1:0][DRAW_W-1:0] prob_tab_t;
  typedef logic [COORD_IN_N-1:0][COORD_MAX_W-1:0]  mod_tab_t;

  // 1 - exp(-0.5*n) in q32, exp term built by repeated rounded products
  function automatic prob_tab_t build_prob_table(input int entries);
    prob_tab_t   tab;
    logic [63:0] e;
    logic [63:0] p;
    tab = '0;
    e   = ONE_Q32;
    for (int n = 0; n < PROB_MAX_ENTRIES; n++) begin
      if (n > 0) begin
        e = (e * EXP_HALF_Q32 + HALF_LSB_Q32) >> 32;
      end
      p = ONE_Q32 - e;
      if (p > 64'h0000_0000_FFFF_FFFF) begin
        p = 64'h0000_0000_FFFF_FFFF;
      end
      if (n < entries) begin
        tab[n] = p[DRAW_W-1:0];
      end
    end
    return tab;
  endfunction

  // coordinate reduced modulo the grid size, by counting
  function automatic mod_tab_t build_mod_table(input int grid);
    mod_tab_t tab;
    int       v;
    v = 0;
    for (int i = 0; i < COORD_IN_N; i++) begin
      tab[i] = COORD_MAX_W'(v);
      v = v + 1;
      if (v == grid) begin
        v = 0;
      end
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sagu_ram.sv =====
// generic single-port ram with registered read
// no dependencies
`default_nettype none

module sagu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/seirs_agent_grid_update.sv =====
// top level of the seirs agent grid update block: sequencer, shared adder, output register
// depends on sagu_pkg and sagu_ram
//
// usage
//   s_axis carries one command per transfer; tuser holds the operation
//   (clear cell, add infected to cell, update agent), tdata the position,
//   agent record, uniform draw and fresh durations. clear and add produce
//   no result; an update produces one result transfer on m_axis.
//   cfg_* writes compare_mode, redraw_enable and live_grid; cfg_ready is
//   always high, write only while the block is idle.
// sequence
//   clear writes zero to the cell; add reads the cell, then writes it back; an
//   update runs from accept to a result in the output register: the nine
//   neighbourhood reads go one per cycle through the single cell ram port
//   into one shared adder, then a drain step, a decide step (table
//   lookup, compares, optional live write-back) and an output load.
//   s_axis_tready is high only while the sequencer is idle.
// reset
//   rst clears the sequencer, output valid and the config registers.
//   cell counts are not cleared; clear each cell before it is read.
// stalls
//   a waiting result sits in the output register; the next command is
//   still taken and worked on, and a later result waits in the decide
//   registers until m_axis_tready frees the output register.
`default_nettype none

module seirs_agent_grid_update #(
  parameter int GRID_SIZE          = sagu_pkg::GRID_SIZE_DEF,
  parameter int PROB_TABLE_ENTRIES = sagu_pkg::PROB_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // command stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // low to high: cell_row[7:0], cell_col[15:8], agent_state[17:16],
  // elapsed_days[29:18], exposed_days[41:30], infectious_days[53:42],
  // recovered_days[65:54], uniform_draw[97:66], fresh_exposed_days[109:98],
  // fresh_infectious_days[121:110], fresh_recovered_days[133:122], zero pad
  input  logic [sagu_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // operation[1:0]
  input  logic [sagu_pkg::OP_W-1:0]        s_axis_tuser,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // low to high: next_state[1:0], next_elapsed[13:2], out_exposed_days[25:14],
  // out_infectious_days[37:26], out_recovered_days[49:38],
  // infected_seen[69:50], zero pad
  output logic [sagu_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // config write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sagu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic                             cfg_data
);

  import sagu_pkg::*;

  localparam int COORD_W = $clog2(GRID_SIZE);
  localparam int ADDR_W  = $clog2(GRID_SIZE * GRID_SIZE);
  localparam int PIDX_W  = $clog2(PROB_TABLE_ENTRIES);

  localparam logic [COORD_W-1:0] COORD_LAST = COORD_W'(GRID_SIZE - 1);
  localparam logic [ADDR_W-1:0]  GRID_A     = ADDR_W'(GRID_SIZE);
  localparam logic [SEEN_W-1:0]  PROB_LAST  = SEEN_W'(PROB_TABLE_ENTRIES - 1);
  localparam logic [PIDX_W-1:0]  PIDX_LAST  = PIDX_W'(PROB_TABLE_ENTRIES - 1);

  localparam prob_tab_t PROB_FULL = build_prob_table(PROB_TABLE_ENTRIES);
  localparam logic [PROB_TABLE_ENTRIES-1:0][DRAW_W-1:0] PROB_LUT =
    PROB_FULL[PROB_TABLE_ENTRIES-1:0];
  localparam mod_tab_t MOD_LUT = build_mod_table(GRID_SIZE);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CENTER,
    S_ADD,
    S_WRITE,
    S_READ,
    S_DRAIN,
    S_DECIDE,
    S_OUT
  } state_t;

  state_t state;

  // config registers
  logic compare_mode;
  logic redraw_enable;
  logic live_grid;

  // latched command
  agent_t             ag_state;
  logic [DAYS_W-1:0]  el, de, di, dr, fde, fdi, fdr;
  logic [DRAW_W-1:0]  draw;
  logic [COORD_W-1:0] r_lo, r_mid, r_hi, c_lo, c_mid, c_hi;

  // neighbourhood walk
  logic [1:0]        rsel, csel;
  logic              rd_pend;
  logic              rd_center;
  logic [SEEN_W-1:0] sum;
  logic [CELL_W-1:0] center;

  // decided result
  agent_t            res_state;
  logic [DAYS_W-1:0] res_el, res_de, res_di, res_dr;

  // output register
  agent_t            o_state;
  logic [DAYS_W-1:0] o_el, o_de, o_di, o_dr;
  logic [SEEN_W-1:0] o_seen;
  logic              o_valid;

  // cell ram port
  logic [ADDR_W-1:0]  ram_addr;
  logic               ram_we;
  logic [CELL_W-1:0]  ram_wdata;
  logic [CELL_W-1:0]  ram_rdata;
  logic [COORD_W-1:0] a_row, a_col;

  // shared adder: accumulates the neighbourhood, increments on add
  logic [SEEN_W-1:0] alu_a, alu_b, alu_y;

  // input coordinates reduced onto the grid
  logic [COORD_W-1:0] in_row, in_col;

  // decide logic
  logic [PIDX_W-1:0] pidx;
  logic              infect;
  logic              pass_e, pass_i, pass_r;
  agent_t            nst;
  logic              moved, redraw, live_inc, live_dec;
  logic [DAYS_W-1:0] nel;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {2'b00, o_seen, o_dr, o_di, o_de, o_el, o_state};

  assign in_row = MOD_LUT[s_axis_tdata[7:0]][COORD_W-1:0];
  assign in_col = MOD_LUT[s_axis_tdata[15:8]][COORD_W-1:0];

  // neighbour select, rsel/csel = 1 picks the agent's own cell
  always_comb begin
    case (rsel)
      2'd0:    a_row = r_lo;
      2'd2:    a_row = r_hi;
      default: a_row = r_mid;
    endcase
    case (csel)
      2'd0:    a_col = c_lo;
      2'd2:    a_col = c_hi;
      default: a_col = c_mid;
    endcase
  end

  assign ram_addr = ADDR_W'(a_row) * GRID_A + ADDR_W'(a_col);

  always_comb begin
    if (state == S_ADD) begin
      alu_a = SEEN_W'(ram_rdata);
      alu_b = SEEN_W'(1);
    end else begin
      alu_a = sum;
      alu_b = SEEN_W'(ram_rdata);
    end
    alu_y = alu_a + alu_b;
  end

  // transition decision on the latched agent and the finished sum
  always_comb begin
    pidx     = (sum < PROB_LAST) ? sum[PIDX_W-1:0] : PIDX_LAST;
    infect   = (draw < PROB_LUT[pidx]);
    pass_e   = compare_mode ? (el >= de) : (el > de);
    pass_i   = compare_mode ? (el >= di) : (el > di);
    pass_r   = compare_mode ? (el >= dr) : (el > dr);
    nst      = ag_state;
    moved    = 1'b0;
    redraw   = 1'b0;
    live_inc = 1'b0;
    live_dec = 1'b0;
    unique case (ag_state)
      AG_SUS: begin
        moved = 1'b1;  // susceptible always restarts its day count
        if (infect) begin
          nst    = AG_EXP;
          redraw = redraw_enable;
        end
      end
      AG_EXP: begin
        if (pass_e) begin
          nst      = AG_INF;
          moved    = 1'b1;
          live_inc = live_grid;
        end
      end
      AG_INF: begin
        if (pass_i) begin
          nst      = AG_REC;
          moved    = 1'b1;
          live_dec = live_grid;
        end
      end
      AG_REC: begin
        if (pass_r) begin
          nst   = AG_SUS;
          moved = 1'b1;
        end
      end
      default: begin
        nst = ag_state;
      end
    endcase
    if (moved) begin
      nel = '0;
    end else if (el == DAYS_MAX) begin
      nel = DAYS_MAX;
    end else begin
      nel = el + DAYS_W'(1);
    end
  end

  // cell ram write: clear, saturating add, live-grid adjust
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    unique case (state)
      S_WRITE: begin
        ram_we = 1'b1;
      end
      S_ADD: begin
        ram_we    = (ram_rdata != CELL_MAX);
        ram_wdata = alu_y[CELL_W-1:0];
      end
      S_DECIDE: begin
        if (live_inc && center != CELL_MAX) begin
          ram_we    = 1'b1;
          ram_wdata = center + CELL_W'(1);
        end else if (live_dec && center != '0) begin
          ram_we    = 1'b1;
          ram_wdata = center - CELL_W'(1);
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  sagu_ram #(
    .WIDTH (CELL_W),
    .DEPTH (GRID_SIZE * GRID_SIZE)
  ) u_cells (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      compare_mode  <= 1'b0;
      redraw_enable <= 1'b0;
      live_grid     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COMPARE_MODE:  compare_mode  <= cfg_data;
        CFG_REDRAW_ENABLE: redraw_enable <= cfg_data;
        CFG_LIVE_GRID:     live_grid     <= cfg_data;
        default:           compare_mode  <= compare_mode;
      endcase
    end
  end

  // sequencer and its registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      o_valid <= 1'b0;
      rd_pend <= 1'b0;
      rsel    <= 2'd1;
      csel    <= 2'd1;
    end else begin
      // the output load step sets valid again itself
      if (o_valid && m_axis_tready && state != S_OUT) begin
        o_valid <= 1'b0;
      end

      // read data of the previous cycle lands in the adder
      rd_pend <= (state == S_READ);
      if (rd_pend && (state == S_READ || state == S_DRAIN)) begin
        sum <= alu_y;
        if (rd_center) begin
          center <= ram_rdata;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            ag_state <= agent_t'(s_axis_tdata[17:16]);
            el       <= s_axis_tdata[29:18];
            de       <= s_axis_tdata[41:30];
            di       <= s_axis_tdata[53:42];
            dr       <= s_axis_tdata[65:54];
            draw     <= s_axis_tdata[97:66];
            fde      <= s_axis_tdata[109:98];
            fdi      <= s_axis_tdata[121:110];
            fdr      <= s_axis_tdata[133:122];
            r_mid    <= in_row;
            c_mid    <= in_col;
            r_lo     <= (in_row == '0) ? COORD_LAST : in_row - COORD_W'(1);
            r_hi     <= (in_row == COORD_LAST) ? '0 : in_row + COORD_W'(1);
            c_lo     <= (in_col == '0) ? COORD_LAST : in_col - COORD_W'(1);
            c_hi     <= (in_col == COORD_LAST) ? '0 : in_col + COORD_W'(1);
            sum      <= '0;
            case (s_axis_tuser)
              OP_CLEAR: begin
                state <= S_WRITE;
                rsel  <= 2'd1;
                csel  <= 2'd1;
              end
              OP_ADD: begin
                state <= S_CENTER;
                rsel  <= 2'd1;
                csel  <= 2'd1;
              end
              OP_UPDATE: begin
                state <= S_READ;
                rsel  <= 2'd0;
                csel  <= 2'd0;
              end
              default: begin
                state <= S_IDLE;  // unknown operation, dropped
                rsel  <= 2'd1;
                csel  <= 2'd1;
              end
            endcase
          end
        end
        S_CENTER: begin
          state <= S_ADD;
        end
        S_ADD: begin
          state <= S_IDLE;
        end
        S_WRITE: begin
          state <= S_IDLE;
        end
        S_READ: begin
          rd_center <= (rsel == 2'd1) && (csel == 2'd1);
          if (csel == 2'd2) begin
            if (rsel == 2'd2) begin
              rsel  <= 2'd1;
              csel  <= 2'd1;
              state <= S_DRAIN;
            end else begin
              csel <= 2'd0;
              rsel <= rsel + 2'd1;
            end
          end else begin
            csel <= csel + 2'd1;
          end
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          res_state <= nst;
          res_el    <= nel;
          res_de    <= redraw ? fde : de;
          res_di    <= redraw ? fdi : di;
          res_dr    <= redraw ? fdr : dr;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!o_valid || m_axis_tready) begin
            o_state <= res_state;
            o_el    <= res_el;
            o_de    <= res_de;
            o_di    <= res_di;
            o_dr    <= res_dr;
            o_seen  <= sum;
            o_valid <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the neighbourhood walk must not be disturbed by a write
  assert property (@(posedge clk) disable iff (rst) (state == S_READ) |-> !ram_we)
    else $error("cell write during neighbourhood read");

  // the last neighbour's data is still in flight when draining
  assert property (@(posedge clk) disable iff (rst) (state == S_DRAIN) |-> rd_pend)
    else $error("drain without pending read data");

  // a new result appears only from the output load step
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == S_OUT))
    else $error("result valid raised outside output load");

  // a state change always restarts the day count
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && res_state != ag_state) |-> (res_el == '0))
    else $error("elapsed not cleared on transition");

  // nine 16-bit counts cannot exceed nine times the cell maximum
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (sum <= SEEN_W'(9 * 65535)))
    else $error("neighbourhood sum out of range");

endmodule

`default_nettype wire
